[design/wlt_pkg.sv]
`timescale 1ns / 1ps
package wlt_pkg;
    localparam int NUM_VARS = 256;
    localparam int WEIGHT_BITS = 40;
    localparam int NUM_LITS = 2 * NUM_VARS;
    localparam int VAR_W = 8;
    localparam int LIT_W = $clog2(NUM_LITS);
    localparam int AB_W = $clog2(NUM_VARS);
    localparam int CNT_W = $clog2(NUM_LITS + 1);
    localparam int VAL_W = 48;
    localparam int AMT_W = 41;
    localparam int SUM_W = 64;
    localparam int OP_W = 4;

    localparam logic [OP_W-1:0] OP_ADDW = 4'd0;
    localparam logic [OP_W-1:0] OP_ADDC = 4'd1;
    localparam logic [OP_W-1:0] OP_RDW  = 4'd2;
    localparam logic [OP_W-1:0] OP_RDC  = 4'd3;
    localparam logic [OP_W-1:0] OP_MAX  = 4'd4;
    localparam logic [OP_W-1:0] OP_MIN  = 4'd5;
    localparam logic [OP_W-1:0] OP_MAXB = 4'd6;
    localparam logic [OP_W-1:0] OP_CAN  = 4'd7;
    localparam logic [OP_W-1:0] OP_SETB = 4'd8;
    localparam logic [OP_W-1:0] OP_COST = 4'd9;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_NEG = 2'd2;
    localparam logic [1:0] ST_SAT = 2'd3;

    localparam logic [SUM_W-1:0] VALUE_MAX = {{(SUM_W-VAL_W){1'b0}}, {VAL_W{1'b1}}};
    localparam logic [SUM_W-1:0] WEIGHT_MAX =
        {{(SUM_W-WEIGHT_BITS){1'b0}}, {WEIGHT_BITS{1'b1}}};

    // controller commands to datapath
    typedef struct packed {
        logic clear_step;   // clear one entry during the post-reset sweep
        logic load;         // latch incoming word, issue first read
        logic scan_rd;      // issue read of scan entry
        logic scan_acc;     // fold read data of previous scan entry
        logic single_exec;  // execute a single-entry or register op
        logic can_hold_n;   // canonicalize: hold negated weight of the pair
        logic can_wr_n;     // canonicalize: write negated entry of pair
        logic can_wr_p;     // canonicalize: write positive entry of pair
        logic finish;       // load the output register
    } wlt_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic scan_last;
        logic is_scan;
        logic is_can;
    } wlt_sts_t;
endpackage

[design/wlt_datapath.sv]
`timescale 1ns / 1ps
module wlt_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  wlt_pkg::wlt_cmd_t                   cmd,
    output wlt_pkg::wlt_sts_t                   sts,
    input  logic [wlt_pkg::OP_W-1:0]            op,
    input  logic [wlt_pkg::VAR_W-1:0]           variable,
    input  logic                                polarity,
    input  logic signed [wlt_pkg::AMT_W-1:0]    amount,
    input  logic                                truth_bit,
    output logic [wlt_pkg::VAL_W-1:0]           value,
    output logic [1:0]                          status
);
    import wlt_pkg::*;

    logic [WEIGHT_BITS-1:0] mem [NUM_LITS];
    logic                   bits [NUM_VARS];
    logic [WEIGHT_BITS-1:0] rd_reg;
    logic                   bit_rd_reg;
    logic [LIT_W-1:0]       clr_reg;
    logic                   clr_done_reg;

    logic [OP_W-1:0]        op_reg;
    logic [VAR_W-1:0]       var_reg;
    logic                   pol_reg;
    logic signed [AMT_W-1:0] amt_reg;
    logic                   tb_reg;
    logic [LIT_W:0]         scan_reg;     // scan counter with room for end
    logic [SUM_W-1:0]       acc_reg;
    logic                   sat_reg;
    logic [SUM_W-1:0]       const_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [WEIGHT_BITS-1:0] pair_n_reg;
    logic [VAL_W-1:0]       value_reg;
    logic [1:0]             status_reg;

    logic                   in_range;
    logic [LIT_W-1:0]       lit_idx;
    logic [LIT_W-1:0]       rd_addr;
    logic                   rd_en;
    logic                   wr_en;
    logic [LIT_W-1:0]       wr_addr;
    logic [WEIGHT_BITS-1:0] wr_data;
    logic                   cnt_inc;
    logic                   cnt_dec;
    logic [LIT_W-1:0]       scan_idx;
    logic [LIT_W-1:0]       acc_idx;

    assign in_range = ({24'd0, var_reg} < NUM_VARS);
    assign lit_idx  = LIT_W'({var_reg, pol_reg});
    assign scan_idx = scan_reg[LIT_W-1:0];
    assign acc_idx  = LIT_W'(scan_reg[LIT_W-1:0] - 1'b1);

    // read port address
    always_comb
    begin
        rd_en = 1'b0;
        rd_addr = lit_idx;
        if (cmd.load)
        begin
            rd_en = 1'b1;
            rd_addr = LIT_W'({variable, polarity});
        end
        else if (cmd.scan_rd)
        begin
            rd_en = 1'b1;
            rd_addr = scan_idx;
        end
    end

    // add-weight arithmetic
    logic signed [SUM_W-1:0] addw_sum;
    logic [SUM_W-1:0]        addw_w;
    logic [1:0]              addw_st;
    logic                    addw_write;
    always_comb
    begin
        addw_sum = $signed({{(SUM_W-WEIGHT_BITS){1'b0}}, rd_reg}) +
                   SUM_W'(amt_reg);
        addw_write = 1'b0;
        addw_st = ST_OK;
        addw_w = {{(SUM_W-WEIGHT_BITS){1'b0}}, in_range ? rd_reg : '0};
        if (amt_reg == '0)
            addw_st = ST_REJECT;
        else if (addw_sum < 0)
            addw_st = ST_NEG;
        else
        begin
            addw_w = addw_sum;
            if (addw_w > WEIGHT_MAX)
            begin
                addw_w = WEIGHT_MAX;
                addw_st = ST_SAT;
            end
            addw_write = in_range;
            if (!in_range)
                addw_w = '0;
        end
    end

    // canonicalize pair arithmetic (rd_reg holds positive weight, pair_n_reg the negated)
    logic [WEIGHT_BITS-1:0] pmin;
    logic                   pboth;
    logic [SUM_W-1:0]       csum;
    logic                   csat;
    always_comb
    begin
        pmin = (pair_n_reg < rd_reg) ? pair_n_reg : rd_reg;
        pboth = (pair_n_reg != '0) && (rd_reg != '0);
        csum = const_reg + {{(SUM_W-WEIGHT_BITS){1'b0}}, pmin};
        csat = (csum > VALUE_MAX);
    end

    // memory write port
    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = lit_idx;
        wr_data = addw_w[WEIGHT_BITS-1:0];
        cnt_inc = 1'b0;
        cnt_dec = 1'b0;
        if (cmd.clear_step)
        begin
            wr_en = 1'b1;
            wr_addr = clr_reg;
            wr_data = '0;
        end
        else if (cmd.single_exec && op_reg == OP_ADDW && addw_write)
        begin
            wr_en = 1'b1;
            cnt_inc = (rd_reg == '0) && (addw_w != '0);
            cnt_dec = (rd_reg != '0) && (addw_w == '0);
        end
        else if (cmd.can_wr_p && pboth)
        begin
            wr_en = 1'b1;
            wr_addr = acc_idx;
            wr_data = rd_reg - pmin;
            cnt_dec = (rd_reg == pmin);
        end
        else if (cmd.can_wr_n && pboth)
        begin
            wr_en = 1'b1;
            wr_addr = LIT_W'({acc_idx[LIT_W-1:1], 1'b0});
            wr_data = pair_n_reg - pmin;
            cnt_dec = (pair_n_reg == pmin);
        end
    end

    // weight memory: one read, one write port, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_reg <= mem[rd_addr];
    end

    // assignment bits: valid only after the clearing sweep has passed them;
    // read alongside the weight of the same scan entry
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step && clr_reg[0])
            bits[clr_reg[LIT_W-1:1]] <= 1'b0;
        else if (cmd.single_exec && op_reg == OP_SETB && in_range)
            bits[var_reg[AB_W-1:0]] <= tb_reg;
        if (cmd.scan_rd)
            bit_rd_reg <= bits[scan_idx[LIT_W-1:1]];
    end

    // clearing sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
            clr_done_reg <= 1'b0;
        end
        else if (cmd.clear_step)
        begin
            clr_reg <= clr_reg + 1'b1;
            if (clr_reg == LIT_W'(NUM_LITS - 1))
                clr_done_reg <= 1'b1;
        end
    end

    // scan fold of one entry
    logic [SUM_W-1:0] rw;
    logic [SUM_W-1:0] th;
    logic [SUM_W-1:0] cost_sum;
    always_comb
    begin
        rw = {{(SUM_W-WEIGHT_BITS){1'b0}}, rd_reg};
        th = SUM_W'(amt_reg);
        cost_sum = acc_reg + rw;
    end

    // architectural registers and scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            const_reg <= '0;
            cnt_reg <= '0;
            scan_reg <= '0;
            acc_reg <= '0;
            sat_reg <= 1'b0;
        end
        else
        begin
            if (cnt_inc)
                cnt_reg <= cnt_reg + 1'b1;
            else if (cnt_dec)
                cnt_reg <= cnt_reg - 1'b1;
            if (cmd.load)
            begin
                scan_reg <= '0;
                sat_reg <= 1'b0;
                acc_reg <= (op == OP_COST) ? const_reg : '0;
            end
            if (cmd.scan_rd)
                scan_reg <= scan_reg + 1'b1;
            if (cmd.single_exec && op_reg == OP_ADDC && !amt_reg[AMT_W-1])
            begin
                if (const_reg + th > VALUE_MAX)
                begin
                    const_reg <= VALUE_MAX;
                    sat_reg <= 1'b1;
                end
                else
                    const_reg <= const_reg + th;
            end
            if (cmd.scan_acc)
            begin
                unique case (op_reg)
                    OP_MAX:
                        if (rw > acc_reg) acc_reg <= rw;
                    OP_MIN:
                        if (rw != '0 && (acc_reg == '0 || rw < acc_reg)) acc_reg <= rw;
                    OP_MAXB:
                        if (!amt_reg[AMT_W-1] && rw < th && rw > acc_reg) acc_reg <= rw;
                    OP_COST:
                        // fold only the literal that the assignment bit makes true
                        if (acc_idx[0] == bit_rd_reg)
                        begin
                            if (cost_sum > VALUE_MAX)
                            begin
                                acc_reg <= VALUE_MAX;
                                sat_reg <= 1'b1;
                            end
                            else
                                acc_reg <= cost_sum;
                        end
                    default:
                        acc_reg <= acc_reg;
                endcase
            end
            if (cmd.can_wr_p && pboth)
            begin
                if (csat)
                begin
                    const_reg <= VALUE_MAX;
                    sat_reg <= 1'b1;
                end
                else
                    const_reg <= csum;
            end
        end
    end

    // hold negated weight of the pair and latch the request word
    always_ff @(posedge clk)
    begin
        if (cmd.can_hold_n)
            pair_n_reg <= rd_reg;
        if (cmd.load)
        begin
            op_reg <= op;
            var_reg <= variable;
            pol_reg <= polarity;
            amt_reg <= amount;
            tb_reg <= truth_bit;
        end
    end

    // result formation
    logic [SUM_W-1:0] res_v;
    logic [1:0]       res_s;
    always_comb
    begin
        res_v = '0;
        res_s = ST_OK;
        unique case (op_reg)
            OP_ADDW:
            begin
                res_v = (addw_st == ST_REJECT || addw_st == ST_NEG) ?
                        {{(SUM_W-WEIGHT_BITS){1'b0}}, in_range ? rd_reg : '0} : addw_w;
                res_s = addw_st;
            end
            OP_ADDC:
            begin
                res_v = const_reg;
                res_s = amt_reg[AMT_W-1] ? ST_REJECT : (sat_reg ? ST_SAT : ST_OK);
            end
            OP_RDW:
                res_v = {{(SUM_W-WEIGHT_BITS){1'b0}}, in_range ? rd_reg : '0};
            OP_RDC:
                res_v = pol_reg ? SUM_W'(cnt_reg) : const_reg;
            OP_MAX, OP_MIN, OP_MAXB:
                res_v = acc_reg;
            OP_CAN:
            begin
                res_v = const_reg;
                res_s = sat_reg ? ST_SAT : ST_OK;
            end
            OP_COST:
            begin
                res_v = acc_reg;
                res_s = sat_reg ? ST_SAT : ST_OK;
            end
            default:
                res_v = '0;
        endcase
        if (res_v > VALUE_MAX)
        begin
            res_v = VALUE_MAX;
            res_s = ST_SAT;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            value_reg <= res_v[VAL_W-1:0];
            status_reg <= res_s;
        end
    end

    assign value = value_reg;
    assign status = status_reg;

    assign sts.clear_done = clr_done_reg;
    assign sts.scan_last = (scan_reg == (LIT_W+1)'(NUM_LITS));
    assign sts.is_scan = (op_reg == OP_MAX) || (op_reg == OP_MIN) ||
                         (op_reg == OP_MAXB) || (op_reg == OP_COST) || (op_reg == OP_CAN);
    assign sts.is_can = (op_reg == OP_CAN);
endmodule

[design/wlt_ctrl.sv]
`timescale 1ns / 1ps
module wlt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  wlt_pkg::wlt_sts_t sts,
    output wlt_pkg::wlt_cmd_t cmd
);
    import wlt_pkg::*;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b00000001,
        S_IDLE  = 8'b00000010,
        S_EXEC  = 8'b00000100,
        S_SCAN  = 8'b00001000,
        S_CANN  = 8'b00010000,
        S_CANP  = 8'b00100000,
        S_CANW  = 8'b01000000,
        S_DONE  = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;
    logic   can_take;

    // accept in idle when the output register is free or being drained
    assign can_take = (state_reg == S_IDLE) && (!ov_reg || !out_stall);
    assign in_stall = !can_take;
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        ov_next = ov_reg && out_stall;
        cmd = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_done)
                begin
                    cmd.clear_step = 1'b0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
                if (in_valid && can_take)
                begin
                    cmd.load = 1'b1;
                    state_next = S_EXEC;
                end
            S_EXEC:
                if (sts.is_scan)
                begin
                    state_next = sts.is_can ? S_CANN : S_SCAN;
                    cmd.scan_rd = 1'b1;
                end
                else
                begin
                    cmd.single_exec = 1'b1;
                    state_next = S_DONE;
                end
            S_SCAN:
            begin
                // read next entry while folding the previous one
                cmd.scan_acc = 1'b1;
                if (sts.scan_last)
                    state_next = S_DONE;
                else
                    cmd.scan_rd = 1'b1;
            end
            S_CANN:
            begin
                // negated weight of the pair has arrived; hold it, fetch positive
                cmd.can_hold_n = 1'b1;
                cmd.scan_rd = 1'b1;
                state_next = S_CANP;
            end
            S_CANP:
            begin
                // write back the positive entry and fold the constant
                cmd.can_wr_p = 1'b1;
                state_next = S_CANW;
            end
            S_CANW:
            begin
                // write back the negated entry, fetch the next pair
                cmd.can_wr_n = 1'b1;
                if (sts.scan_last)
                    state_next = S_DONE;
                else
                begin
                    cmd.scan_rd = 1'b1;
                    state_next = S_CANN;
                end
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                ov_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
        end
    end
endmodule

[design/weighted_literal_table_unit.sv]
`timescale 1ns / 1ps
// Single-entry and register operations show the result after the execute and done
// states; max, min, max below and cost read all 512 entries before the result.
// Canonicalize visits all 256 variable pairs and moves the smaller weight of each into the constant.
// A new word is taken only in the idle state, after the previous result is formed, and
// only when the output register is empty or being drained in that cycle.
// Reset: asynchronous, active low; a clearing sweep then zeroes all 512 table entries.
module weighted_literal_table_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [wlt_pkg::OP_W-1:0]          op,
    input  logic [wlt_pkg::VAR_W-1:0]         variable,
    input  logic                              polarity,
    input  logic signed [wlt_pkg::AMT_W-1:0]  amount,
    input  logic                              truth_bit,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [wlt_pkg::VAL_W-1:0]         value,
    output logic [1:0]                        status
);
    import wlt_pkg::*;

    wlt_cmd_t cmd;
    wlt_sts_t sts;

    wlt_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
    );

    wlt_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .op(op),
        .variable(variable), .polarity(polarity), .amount(amount),
        .truth_bit(truth_bit), .value(value), .status(status)
    );
endmodule

[design/wlt_checker.sv]
`timescale 1ns / 1ps
module wlt_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [wlt_pkg::VAL_W-1:0]   value,
    input logic [1:0]                  status
);
    // hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(value) && $stable(status))
        else $error("stalled result changed");

    // accepted word cannot be followed by another in the next cycle
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second word taken during work");

    // no result in the cycle right after an acceptance into an empty output
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_valid |=> !out_valid)
        else $error("result appeared too early");
endmodule

bind weighted_literal_table_unit wlt_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .value(value), .status(status)
);
